### hdl/pmftl_pkg.sv
package pmftl_pkg;

    localparam int BLOCKS        = 32;
    localparam int PAGES         = 16;
    localparam int LOGICAL_PAGES = 256;

    localparam int BLK_W  = $clog2(BLOCKS);
    localparam int PG_W   = $clog2(PAGES);
    localparam int PGC_W  = $clog2(PAGES + 1);
    localparam int LBA_W  = $clog2(LOGICAL_PAGES);
    localparam int TOTAL  = BLOCKS * PAGES;
    localparam int SCAN_W = $clog2(TOTAL + PAGES) + 1;
    localparam int ROW_W  = 2 * PAGES;
    localparam int CNT_W  = $clog2(PAGES + 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_BAD_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LBA_LIMIT = 2'd1;

    localparam logic [1:0] PS_FREE  = 2'd0;
    localparam logic [1:0] PS_LIVE  = 2'd1;
    localparam logic [1:0] PS_STALE = 2'd2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TRIM  = 2'd2;
    localparam logic [1:0] OP_GC    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ADDR = 2'd1;
    localparam logic [1:0] ST_UNMAPPED = 2'd2;
    localparam logic [1:0] ST_NO_SPACE = 2'd3;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_PROGRAM = 3'd1;
    localparam logic [2:0] CMD_READ    = 3'd2;
    localparam logic [2:0] CMD_ERASE   = 3'd3;
    localparam logic [2:0] CMD_COPY    = 3'd4;

    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] lba;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] command;
        logic [4:0] src_block;
        logic [3:0] src_page;
        logic [4:0] dst_block;
        logic [3:0] dst_page;
        logic       last;
    } t_out;

    typedef struct packed {
        logic             found;
        logic [PG_W-1:0]  pg;
        logic [CNT_W-1:0] inv_cnt;
        logic [CNT_W-1:0] val_cnt;
    } t_scan;

    function automatic t_row row_set(t_row r, logic [PG_W-1:0] p, logic [1:0] v);
        t_row t;
        t = r;
        t[p*2 +: 2] = v;
        return t;
    endfunction

endpackage

### hdl/pmftl_rowscan.sv
module pmftl_rowscan (
    input  pmftl_pkg::t_row               i_row,
    input  logic [pmftl_pkg::PG_W-1:0]    i_from,
    input  logic [pmftl_pkg::PGC_W-1:0]   i_lim,
    output pmftl_pkg::t_scan              o_scan
);
    import pmftl_pkg::*;

    always_comb begin
        logic [1:0] st;
        o_scan = '0;
        for (int p = 0; p < PAGES; p++) begin
            st = i_row[p*2 +: 2];
            if (st == PS_STALE) o_scan.inv_cnt = o_scan.inv_cnt + CNT_W'(1);
            if (st == PS_LIVE)  o_scan.val_cnt = o_scan.val_cnt + CNT_W'(1);
            // first free page in [from, lim)
            if (!o_scan.found && (PGC_W'(p) >= PGC_W'(i_from)) && (PGC_W'(p) < i_lim)
                && (st == PS_FREE)) begin
                o_scan.found = 1'b1;
                o_scan.pg    = PG_W'(p);
            end
        end
    end

endmodule

### hdl/page_mapped_ftl_with_gc_core.sv
// Page-mapped flash translation layer with greedy garbage collection.
// Requests (op, lba) arrive on a valid/ready input channel; each produces one
// or more NAND command results on a valid/ready output channel, the final one
// of a request flagged by last. One request is worked on at a time.
// Configuration (bad block mask, lba limit) is a separate valid/ready write
// channel that is always ready; write it only while no request is in flight.
// A write walks the allocation cursor one block row at a time. Collection
// reads every block row, then per valid victim page one owner read plus an
// allocation walk, and finally the erase.
// Each transfer out goes through one output register; a stalled receiver
// holds the engine at the next result, and no result is lost.
// Reset: map valid bits (one per logical page) and row valid bits (one per
// block) clear at once, so the block accepts requests straight out of
// reset; there is no clearing pass. Cursor returns to block 0, page 0.
module page_mapped_ftl_with_gc_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pmftl_pkg::t_in                    i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pmftl_pkg::t_out                   o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pmftl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pmftl_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import pmftl_pkg::*;

    // FSM codes
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_RT_MAP  = 5'd2;
    localparam logic [4:0] S_TR_EV   = 5'd3;
    localparam logic [4:0] S_EMIT    = 5'd4;
    localparam logic [4:0] S_AL      = 5'd5;
    localparam logic [4:0] S_AL_EV   = 5'd6;
    localparam logic [4:0] S_W_MAP   = 5'd7;
    localparam logic [4:0] S_W_OLD   = 5'd8;
    localparam logic [4:0] S_W_RDN   = 5'd9;
    localparam logic [4:0] S_W_NEW   = 5'd10;
    localparam logic [4:0] S_GC_RD   = 5'd11;
    localparam logic [4:0] S_GC_EV   = 5'd12;
    localparam logic [4:0] S_GC_DEC  = 5'd13;
    localparam logic [4:0] S_GC_VR   = 5'd14;
    localparam logic [4:0] S_CP      = 5'd15;
    localparam logic [4:0] S_CP_OWN  = 5'd16;
    localparam logic [4:0] S_CP_NEXT = 5'd17;
    localparam logic [4:0] S_C_FAIL  = 5'd18;
    localparam logic [4:0] S_ERASE   = 5'd19;

    // allocation caller
    localparam logic [1:0] AC_W1 = 2'd0;   // write, first try
    localparam logic [1:0] AC_W2 = 2'd1;   // write, after collection
    localparam logic [1:0] AC_CP = 2'd2;   // collection copy

    localparam int MAP_W = BLK_W + PG_W;
    localparam int OWN_A = BLK_W + PG_W;

    // configuration
    logic [BLOCKS-1:0] r_bad;
    logic [8:0]        r_lim;

    // control
    logic [4:0]        r_state, n_state, r_after, n_after;
    logic [1:0]        r_op, n_op;
    logic [LBA_W-1:0]  r_lba, n_lba;
    t_out              r_pend, n_pend;
    t_out              r_out;
    logic              r_out_valid;
    logic [BLK_W-1:0]  r_cb, n_cb;
    logic [PG_W-1:0]   r_cp, n_cp;
    logic [SCAN_W-1:0] r_scan, n_scan;
    logic [1:0]        r_actx, n_actx;
    logic [BLK_W-1:0]  r_nb, n_nb, r_oblk, n_oblk;
    logic [PG_W-1:0]   r_np, n_np, r_opg, n_opg;
    logic [BLK_W-1:0]  r_gb, n_gb, r_victim, n_victim;
    logic              r_have_v, n_have_v;
    logic [CNT_W-1:0]  r_best_inv, n_best_inv, r_best_val, n_best_val;
    t_row              r_vrow, n_vrow;
    logic [PG_W-1:0]   r_vp, n_vp;
    logic [LBA_W-1:0]  r_owner, n_owner;

    // page state rows: one row per block, row valid bit per block
    t_row              mem_st [BLOCKS];
    logic [BLOCKS-1:0] r_rok;
    t_row              r_st_rd;
    logic              r_st_ok;
    logic              st_re, st_we;
    logic [BLK_W-1:0]  st_ra, st_wa;
    t_row              st_wd, row_eff;

    // owner memory
    logic [LBA_W-1:0]  mem_own [TOTAL];
    logic [LBA_W-1:0]  r_own_rd;
    logic              own_re, own_we;
    logic [OWN_A-1:0]  own_ra, own_wa;
    logic [LBA_W-1:0]  own_wd;

    // map memory plus valid flops
    logic [MAP_W-1:0]         mem_map [LOGICAL_PAGES];
    logic [LOGICAL_PAGES-1:0] r_mvalid;
    logic [MAP_W-1:0]         r_map_rd;
    logic                     map_re, map_we;
    logic [LBA_W-1:0]         map_ra, map_wa;
    logic [MAP_W-1:0]         map_wd;
    logic                     mv_we, mv_d;
    logic [LBA_W-1:0]         mv_a;

    logic              emit_go;
    logic [SCAN_W-1:0] rem, span;
    logic [PGC_W-1:0]  lim;
    logic [PG_W-1:0]   scan_from;
    t_scan             scan;
    logic [BLK_W-1:0]  map_blk;
    logic [PG_W-1:0]   map_pg;

    function automatic t_out mk(logic [1:0] st, logic [2:0] cmd, logic [BLK_W-1:0] sb,
                                logic [PG_W-1:0] sp, logic [BLK_W-1:0] db,
                                logic [PG_W-1:0] dp, logic lst);
        t_out o;
        o.status    = st;
        o.command   = cmd;
        o.src_block = 5'(sb);
        o.src_page  = 4'(sp);
        o.dst_block = 5'(db);
        o.dst_page  = 4'(dp);
        o.last      = lst;
        return o;
    endfunction

    function automatic logic [BLK_W-1:0] nxt_blk(logic [BLK_W-1:0] b);
        return (b == BLK_W'(BLOCKS - 1)) ? '0 : b + BLK_W'(1);
    endfunction

    assign row_eff   = r_st_ok ? r_st_rd : '0;
    assign map_blk   = r_map_rd[MAP_W-1 -: BLK_W];
    assign map_pg    = r_map_rd[PG_W-1:0];
    assign rem       = SCAN_W'(TOTAL) - r_scan;
    assign span      = SCAN_W'(PAGES) - SCAN_W'(r_cp);
    assign lim       = (rem < span) ? PGC_W'(SCAN_W'(r_cp) + rem) : PGC_W'(PAGES);
    assign scan_from = (r_state == S_AL_EV) ? r_cp : '0;
    assign emit_go   = !r_out_valid || i_out_ready;

    pmftl_rowscan u_scan (
        .i_row  (row_eff),
        .i_from (scan_from),
        .i_lim  (lim),
        .o_scan (scan)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        logic excl;
        n_state = r_state;   n_after = r_after;   n_op = r_op;      n_lba = r_lba;
        n_pend = r_pend;     n_cb = r_cb;         n_cp = r_cp;      n_scan = r_scan;
        n_actx = r_actx;     n_nb = r_nb;         n_np = r_np;      n_oblk = r_oblk;
        n_opg = r_opg;       n_gb = r_gb;         n_victim = r_victim;
        n_have_v = r_have_v; n_best_inv = r_best_inv;   n_best_val = r_best_val;
        n_vrow = r_vrow;     n_vp = r_vp;         n_owner = r_owner;
        st_re = 1'b0;  st_ra = '0;  st_we = 1'b0;  st_wa = '0;  st_wd = '0;
        own_re = 1'b0; own_ra = '0; own_we = 1'b0; own_wa = '0; own_wd = '0;
        map_re = 1'b0; map_ra = '0; map_we = 1'b0; map_wa = '0; map_wd = '0;
        mv_we = 1'b0;  mv_a = '0;   mv_d = 1'b0;
        excl = (r_actx == AC_CP) && (r_cb == r_victim);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in.op;
                    n_lba   = LBA_W'(i_in.lba);
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (r_op == OP_GC) begin
                    n_gb = '0;  n_have_v = 1'b0;  n_state = S_GC_RD;
                end else if ({1'b0, r_lba} >= r_lim) begin
                    n_pend  = mk(ST_BAD_ADDR, CMD_NONE, '0, '0, '0, '0, 1'b1);
                    n_after = S_IDLE;  n_state = S_EMIT;
                end else if (r_op == OP_WRITE) begin
                    n_scan = '0;  n_actx = AC_W1;  n_state = S_AL;
                end else begin
                    map_re = 1'b1;  map_ra = r_lba;  n_state = S_RT_MAP;
                end
            end
            S_RT_MAP: begin
                n_after = S_IDLE;
                if (!r_mvalid[r_lba]) begin
                    n_pend  = mk(ST_UNMAPPED, CMD_NONE, '0, '0, '0, '0, 1'b1);
                    n_state = S_EMIT;
                end else if (r_op == OP_READ) begin
                    n_pend  = mk(ST_OK, CMD_READ, map_blk, map_pg, '0, '0, 1'b1);
                    n_state = S_EMIT;
                end else begin
                    st_re = 1'b1;  st_ra = map_blk;
                    n_nb = map_blk;  n_np = map_pg;  n_state = S_TR_EV;
                end
            end
            S_TR_EV: begin
                st_we = 1'b1;  st_wa = r_nb;  st_wd = row_set(row_eff, r_np, PS_STALE);
                mv_we = 1'b1;  mv_a = r_lba;  mv_d = 1'b0;
                n_pend  = mk(ST_OK, CMD_NONE, '0, '0, '0, '0, 1'b1);
                n_after = S_IDLE;  n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit_go) n_state = r_after;
            end
            S_AL: begin
                if (r_scan >= SCAN_W'(TOTAL)) begin
                    // allocation failed
                    if (r_actx == AC_W1) begin
                        n_gb = '0;  n_have_v = 1'b0;  n_state = S_GC_RD;
                    end else if (r_actx == AC_W2) begin
                        n_pend  = mk(ST_NO_SPACE, CMD_NONE, '0, '0, '0, '0, 1'b1);
                        n_after = S_IDLE;  n_state = S_EMIT;
                    end else begin
                        n_state = S_C_FAIL;
                    end
                end else if (excl || r_bad[r_cb]) begin
                    n_scan = r_scan + span;  n_cp = '0;  n_cb = nxt_blk(r_cb);
                end else begin
                    st_re = 1'b1;  st_ra = r_cb;  n_state = S_AL_EV;
                end
            end
            S_AL_EV: begin
                if (scan.found) begin
                    n_nb = r_cb;  n_np = scan.pg;
                    if (scan.pg == PG_W'(PAGES - 1)) begin
                        n_cp = '0;  n_cb = nxt_blk(r_cb);
                    end else begin
                        n_cp = scan.pg + PG_W'(1);
                    end
                    if (r_actx == AC_CP) begin
                        // copy lands here: row just read is the target row
                        st_we  = 1'b1;  st_wa = r_cb;
                        st_wd  = row_set(row_eff, scan.pg, PS_LIVE);
                        own_we = 1'b1;  own_wa = {r_cb, scan.pg};  own_wd = r_owner;
                        map_we = 1'b1;  map_wa = r_owner;  map_wd = {r_cb, scan.pg};
                        mv_we  = 1'b1;  mv_a = r_owner;    mv_d = 1'b1;
                        n_vrow  = row_set(r_vrow, r_vp, PS_STALE);
                        n_pend  = mk(ST_OK, CMD_COPY, r_victim, r_vp, r_cb, scan.pg, 1'b0);
                        n_after = S_CP_NEXT;  n_state = S_EMIT;
                    end else begin
                        map_re = 1'b1;  map_ra = r_lba;  n_state = S_W_MAP;
                    end
                end else if (lim < PGC_W'(PAGES)) begin
                    // scan budget ran out inside this row
                    n_cp   = PG_W'(lim);
                    n_scan = SCAN_W'(TOTAL);
                    n_state = S_AL;
                end else begin
                    n_scan = r_scan + span;  n_cp = '0;  n_cb = nxt_blk(r_cb);
                    n_state = S_AL;
                end
            end
            S_W_MAP: begin
                if (r_mvalid[r_lba]) begin
                    st_re = 1'b1;  st_ra = map_blk;
                    n_oblk = map_blk;  n_opg = map_pg;  n_state = S_W_OLD;
                end else begin
                    st_re = 1'b1;  st_ra = r_nb;  n_state = S_W_NEW;
                end
            end
            S_W_OLD: begin
                st_we = 1'b1;  st_wa = r_oblk;  st_wd = row_set(row_eff, r_opg, PS_STALE);
                n_state = S_W_RDN;
            end
            S_W_RDN: begin
                st_re = 1'b1;  st_ra = r_nb;  n_state = S_W_NEW;
            end
            S_W_NEW: begin
                st_we  = 1'b1;  st_wa = r_nb;  st_wd = row_set(row_eff, r_np, PS_LIVE);
                own_we = 1'b1;  own_wa = {r_nb, r_np};  own_wd = r_lba;
                map_we = 1'b1;  map_wa = r_lba;  map_wd = {r_nb, r_np};
                mv_we  = 1'b1;  mv_a = r_lba;    mv_d = 1'b1;
                n_pend  = mk(ST_OK, CMD_PROGRAM, '0, '0, r_nb, r_np, 1'b1);
                n_after = S_IDLE;  n_state = S_EMIT;
            end
            S_GC_RD: begin
                st_re = 1'b1;  st_ra = r_gb;  n_state = S_GC_EV;
            end
            S_GC_EV: begin
                if (!r_bad[r_gb] && (scan.inv_cnt != '0) &&
                    (!r_have_v || (scan.inv_cnt > r_best_inv) ||
                     ((scan.inv_cnt == r_best_inv) && (scan.val_cnt < r_best_val)))) begin
                    n_have_v = 1'b1;  n_victim = r_gb;
                    n_best_inv = scan.inv_cnt;  n_best_val = scan.val_cnt;
                end
                if (r_gb == BLK_W'(BLOCKS - 1)) n_state = S_GC_DEC;
                else begin
                    n_gb = r_gb + BLK_W'(1);  n_state = S_GC_RD;
                end
            end
            S_GC_DEC: begin
                if (!r_have_v) begin
                    n_pend  = mk(ST_NO_SPACE, CMD_NONE, '0, '0, '0, '0, 1'b1);
                    n_after = S_IDLE;  n_state = S_EMIT;
                end else begin
                    st_re = 1'b1;  st_ra = r_victim;  n_state = S_GC_VR;
                end
            end
            S_GC_VR: begin
                n_vrow = row_eff;  n_vp = '0;  n_state = S_CP;
            end
            S_CP: begin
                if (r_vrow[r_vp*2 +: 2] == PS_LIVE) begin
                    own_re = 1'b1;  own_ra = {r_victim, r_vp};  n_state = S_CP_OWN;
                end else begin
                    n_state = S_CP_NEXT;
                end
            end
            S_CP_OWN: begin
                n_owner = r_own_rd;  n_scan = '0;  n_actx = AC_CP;  n_state = S_AL;
            end
            S_CP_NEXT: begin
                if (r_vp == PG_W'(PAGES - 1)) n_state = S_ERASE;
                else begin
                    n_vp = r_vp + PG_W'(1);  n_state = S_CP;
                end
            end
            S_C_FAIL: begin
                // copies made so far stay; victim keeps its other pages
                st_we = 1'b1;  st_wa = r_victim;  st_wd = r_vrow;
                n_pend  = mk(ST_NO_SPACE, CMD_NONE, '0, '0, '0, '0, 1'b1);
                n_after = S_IDLE;  n_state = S_EMIT;
            end
            S_ERASE: begin
                st_we = 1'b1;  st_wa = r_victim;  st_wd = '0;
                n_pend = mk(ST_OK, CMD_ERASE, r_victim, '0, '0, '0, r_op == OP_GC);
                n_state = S_EMIT;
                if (r_op == OP_GC) n_after = S_IDLE;
                else begin
                    n_after = S_AL;  n_scan = '0;  n_actx = AC_W2;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cb        <= '0;
            r_cp        <= '0;
            r_scan      <= '0;
            r_actx      <= AC_W1;
            r_have_v    <= 1'b0;
            r_bad       <= '0;
            r_lim       <= 9'(LOGICAL_PAGES);
            r_rok       <= '0;
            r_mvalid    <= '0;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_cb     <= n_cb;
            r_cp     <= n_cp;
            r_scan   <= n_scan;
            r_actx   <= n_actx;
            r_have_v <= n_have_v;
            if (r_state == S_EMIT && emit_go) r_out_valid <= 1'b1;
            else if (i_out_ready)             r_out_valid <= 1'b0;
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_BAD_MASK)  r_bad <= BLOCKS'(i_cfg_data);
                if (i_cfg_index == REG_LBA_LIMIT) r_lim <= i_cfg_data[8:0];
            end
            if (st_we) r_rok[st_wa] <= 1'b1;
            if (mv_we) r_mvalid[mv_a] <= mv_d;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_lba      <= n_lba;
        r_pend     <= n_pend;
        r_nb       <= n_nb;
        r_np       <= n_np;
        r_oblk     <= n_oblk;
        r_opg      <= n_opg;
        r_gb       <= n_gb;
        r_victim   <= n_victim;
        r_best_inv <= n_best_inv;
        r_best_val <= n_best_val;
        r_vrow     <= n_vrow;
        r_vp       <= n_vp;
        r_owner    <= n_owner;
        if (r_state == S_EMIT && emit_go) r_out <= r_pend;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (st_we) mem_st[st_wa] <= st_wd;
        if (st_re) begin
            r_st_rd <= mem_st[st_ra];
            r_st_ok <= r_rok[st_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (own_we) mem_own[own_wa] <= own_wd;
        if (own_re) r_own_rd <= mem_own[own_ra];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) mem_map[map_wa] <= map_wd;
        if (map_re) r_map_rd <= mem_map[map_ra];
    end

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DISP))
        else $error("accepted request not dispatched");

    a_last_ends_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && emit_go) |-> (r_pend.last == (r_after == S_IDLE)))
        else $error("last flag does not match end of request");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= SCAN_W'(TOTAL + PAGES))
        else $error("allocation scan count overran");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(r_state == S_EMIT && emit_go))
        else $error("result loaded over a stalled one");

endmodule

### dv/testbench.sv
module testbench;
    import pmftl_pkg::*;

    // Clock, reset, and the three channels of the block.
    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in        in_data;
    logic       out_valid;
    logic       out_ready;
    t_out       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    page_mapped_ftl_with_gc_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Shadow of the translation layer state.
    logic [31:0] bad_mask;
    logic [8:0]  lba_lim;
    logic        map_ok  [LOGICAL_PAGES];
    logic [4:0]  map_blk [LOGICAL_PAGES];
    logic [3:0]  map_pg  [LOGICAL_PAGES];
    logic [1:0]  pstate  [BLOCKS][PAGES];
    logic [7:0]  powner  [BLOCKS][PAGES];
    int          cur_blk;
    int          cur_pg;

    t_in  request_q[$];     // requests waiting for the driver
    t_out nand_cmd_q[$];    // NAND commands still owed by the block

    int  mismatches;
    int  cycle_cnt;
    bit  timed_out;
    bit  in_fire;            // request transfer at the last rising edge

    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  hold_off;           // long receiver stall, cycles left

    function automatic t_out mk(logic [1:0] st, logic [2:0] cmd, int sb, int sp,
                                int db, int dp, logic lst);
        t_out o;
        o.status    = st;
        o.command   = cmd;
        o.src_block = sb[4:0];
        o.src_page  = sp[3:0];
        o.dst_block = db[4:0];
        o.dst_page  = dp[3:0];
        o.last      = lst;
        return o;
    endfunction

    function automatic void advance_cursor_block();
        cur_pg  = 0;
        cur_blk = (cur_blk + 1 >= BLOCKS) ? 0 : cur_blk + 1;
    endfunction

    function automatic void advance_cursor();
        cur_pg++;
        if (cur_pg >= PAGES) advance_cursor_block();
    endfunction

    // Round-robin search for a free page; excl = -1 means no excluded block.
    function automatic bit find_free(int excl, output int b, output int p);
        int scanned;
        scanned = 0;
        b = 0;
        p = 0;
        while (scanned < BLOCKS * PAGES) begin
            if (cur_blk == excl || bad_mask[cur_blk]) begin
                scanned += PAGES - cur_pg;
                advance_cursor_block();
                continue;
            end
            if (pstate[cur_blk][cur_pg] == PS_FREE) begin
                b = cur_blk;
                p = cur_pg;
                advance_cursor();
                return 1'b1;
            end
            advance_cursor();
            scanned++;
        end
        return 1'b0;
    endfunction

    function automatic void push_cmd(t_out o);
        nand_cmd_q.push_back(o);
    endfunction

    // Greedy collection: most invalid pages, then fewest valid, then lowest block.
    function automatic bit run_collection(logic erase_last);
        int victim, best_inv, best_val, inv, val, nb, np, own;
        victim   = -1;
        best_inv = -1;
        best_val = 0;
        for (int b = 0; b < BLOCKS; b++) begin
            if (bad_mask[b]) continue;
            inv = 0;
            val = 0;
            for (int p = 0; p < PAGES; p++) begin
                if (pstate[b][p] == PS_STALE) inv++;
                else if (pstate[b][p] == PS_LIVE) val++;
            end
            if (inv == 0) continue;
            if (inv > best_inv || (inv == best_inv && val < best_val)) begin
                best_inv = inv;
                best_val = val;
                victim   = b;
            end
        end
        if (victim < 0) begin
            push_cmd(mk(ST_NO_SPACE, CMD_NONE, 0, 0, 0, 0, 1'b1));
            return 1'b0;
        end
        for (int p = 0; p < PAGES; p++) begin
            if (pstate[victim][p] != PS_LIVE) continue;
            own = powner[victim][p];
            if (!find_free(victim, nb, np)) begin
                push_cmd(mk(ST_NO_SPACE, CMD_NONE, 0, 0, 0, 0, 1'b1));
                return 1'b0;
            end
            map_ok[own]  = 1'b1;
            map_blk[own] = nb[4:0];
            map_pg[own]  = np[3:0];
            pstate[nb][np] = PS_LIVE;
            powner[nb][np] = own[7:0];
            pstate[victim][p] = PS_STALE;
            push_cmd(mk(ST_OK, CMD_COPY, victim, p, nb, np, 1'b0));
        end
        for (int p = 0; p < PAGES; p++) begin
            pstate[victim][p] = PS_FREE;
            powner[victim][p] = '0;
        end
        push_cmd(mk(ST_OK, CMD_ERASE, victim, 0, 0, 0, erase_last));
        return 1'b1;
    endfunction

    // Work out every NAND command one request causes.
    function automatic void predict_request(t_in rq);
        int b, p, a;
        a = rq.lba;
        if (rq.op == OP_GC) begin
            void'(run_collection(1'b1));
            return;
        end
        if (a >= lba_lim) begin
            push_cmd(mk(ST_BAD_ADDR, CMD_NONE, 0, 0, 0, 0, 1'b1));
            return;
        end
        if (rq.op == OP_READ || rq.op == OP_TRIM) begin
            if (!map_ok[a]) begin
                push_cmd(mk(ST_UNMAPPED, CMD_NONE, 0, 0, 0, 0, 1'b1));
            end else if (rq.op == OP_READ) begin
                push_cmd(mk(ST_OK, CMD_READ, map_blk[a], map_pg[a], 0, 0, 1'b1));
            end else begin
                pstate[map_blk[a]][map_pg[a]] = PS_STALE;
                map_ok[a] = 1'b0;
                push_cmd(mk(ST_OK, CMD_NONE, 0, 0, 0, 0, 1'b1));
            end
            return;
        end
        if (!find_free(-1, b, p)) begin
            if (!run_collection(1'b0)) return;
            if (!find_free(-1, b, p)) begin
                push_cmd(mk(ST_NO_SPACE, CMD_NONE, 0, 0, 0, 0, 1'b1));
                return;
            end
        end
        if (map_ok[a]) pstate[map_blk[a]][map_pg[a]] = PS_STALE;
        map_ok[a]  = 1'b1;
        map_blk[a] = b[4:0];
        map_pg[a]  = p[3:0];
        pstate[b][p] = PS_LIVE;
        powner[b][p] = a[7:0];
        push_cmd(mk(ST_OK, CMD_PROGRAM, 0, 0, b, p, 1'b1));
    endfunction

    // Driver: offers queued requests and sets the receiver's ready at the falling edge.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (request_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                in_data  <= request_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        if (hold_off > 0) begin
            hold_off  <= hold_off - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Monitor: predicts on each request transfer and compares each result
    // transfer against the oldest expectation.
    always @(posedge clk) begin
        t_out exp_cmd;
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire) predict_request(in_data);
        if (rst_n && out_valid && out_ready) begin
            if (nand_cmd_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", out_data);
            end else begin
                exp_cmd = nand_cmd_q.pop_front();
                if (out_data !== exp_cmd) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", exp_cmd, out_data);
                end
            end
        end
    end

    // Cycle limit, generous against the slowest correct run.
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > 900000 && !timed_out) begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_BAD_MASK) bad_mask = val;
        else if (idx == REG_LBA_LIMIT) lba_lim = val[8:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every request went out and every result came back.
    task automatic drain();
        while (request_q.size() > 0 || in_valid || nand_cmd_q.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic t_in rq(logic [1:0] op, int a);
        t_in r;
        r.op  = op;
        r.lba = a[7:0];
        return r;
    endfunction

    // Mostly small logical ranges so that overwrites build invalid pages.
    task automatic queue_random(int n, int span);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 55)      request_q.push_back(rq(OP_WRITE, $urandom_range(span - 1)));
            else if (k < 72) request_q.push_back(rq(OP_READ, $urandom_range(span - 1)));
            else if (k < 84) request_q.push_back(rq(OP_TRIM, $urandom_range(span - 1)));
            else if (k < 92) request_q.push_back(rq(OP_GC, $urandom_range(255)));
            else             request_q.push_back(rq(2'($urandom_range(3)),
                                                    $urandom_range(255)));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        cycle_cnt = 0;
        timed_out = 1'b0;
        in_fire = 1'b0;
        hold_off = 0;
        sender_idle_pct = 20;
        receiver_idle_pct = 86;
        bad_mask = '0;
        lba_lim = 9'd256;
        cur_blk = 0;
        cur_pg = 0;
        for (int i = 0; i < LOGICAL_PAGES; i++) begin
            map_ok[i] = 1'b0;
            map_blk[i] = '0;
            map_pg[i] = '0;
        end
        for (int b = 0; b < BLOCKS; b++)
            for (int p = 0; p < PAGES; p++) begin
                pstate[b][p] = PS_FREE;
                powner[b][p] = '0;
            end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: unmapped reads and trims, collect with no victim, extremes.
        request_q.push_back(rq(OP_READ, 0));
        request_q.push_back(rq(OP_TRIM, 255));
        request_q.push_back(rq(OP_GC, 0));
        request_q.push_back(rq(OP_WRITE, 0));
        request_q.push_back(rq(OP_WRITE, 255));
        request_q.push_back(rq(OP_READ, 255));
        request_q.push_back(rq(OP_WRITE, 0));
        request_q.push_back(rq(OP_READ, 0));
        request_q.push_back(rq(OP_TRIM, 255));
        request_q.push_back(rq(OP_TRIM, 255));
        request_q.push_back(rq(OP_GC, 170));
        request_q.push_back(rq(OP_WRITE, 85));
        drain();

        // Limit the logical range, make address rejects and bad blocks skipped.
        cfg_write(REG_LBA_LIMIT, 32'd1);
        cfg_write(REG_BAD_MASK, 32'hFFFF_FFFE);
        request_q.push_back(rq(OP_WRITE, 1));
        request_q.push_back(rq(OP_READ, 200));
        request_q.push_back(rq(OP_WRITE, 0));
        request_q.push_back(rq(OP_TRIM, 0));
        request_q.push_back(rq(OP_GC, 0));
        drain();

        // Two good blocks only: space runs out, collections and no-space cases.
        cfg_write(REG_LBA_LIMIT, 32'd20);
        cfg_write(REG_BAD_MASK, 32'hFFFF_FFFC);
        queue_random(40, 20);
        drain();

        // Long receiver stall while the sender keeps offering requests.
        cfg_write(REG_BAD_MASK, 32'h0000_0000);
        cfg_write(REG_LBA_LIMIT, 32'h0000_01FF);
        hold_off = 400;
        queue_random(20, 40);
        drain();

        cfg_write(REG_BAD_MASK, 32'hA5A5_5A5A);
        cfg_write(REG_LBA_LIMIT, 32'd256);
        sender_idle_pct = 86;
        receiver_idle_pct = 20;
        queue_random(40, 48);
        drain();

        cfg_write(REG_BAD_MASK, 32'hFFFF_0000);
        cfg_write(REG_LBA_LIMIT, 32'd200);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        queue_random(40, 256);
        drain();

        if (mismatches == 0 && nand_cmd_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### page_mapped_ftl_with_gc_core.f
hdl/pmftl_pkg.sv
hdl/pmftl_rowscan.sv
hdl/page_mapped_ftl_with_gc_core.sv
dv/testbench.sv
